@@ rtl/bdlq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdlq_pkg
// shared types and constants of the box downsample luma quantizer
// ----------------------------------------------------------------------------
package bdlq_pkg;

  localparam int POS_W    = 12;
  localparam int CFG_W    = 13;
  localparam int FACTOR_W = 7;
  localparam int SUM_W    = 20;
  localparam int NUM_W    = 22;
  localparam int HEIGHT_MAX = 4096;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BLOCK_FACTOR = 2'd2;

  localparam logic [9:0] COEF_RED   = 10'd306;
  localparam logic [9:0] COEF_GREEN = 10'd601;
  localparam logic [9:0] COEF_BLUE  = 10'd116;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0]       gray_level;
    logic [4:0]       shade_index;
    logic [POS_W-1:0] out_column;
    logic [POS_W-1:0] out_row;
    logic             frame_last;
  } result_t;

  typedef struct packed {
    logic             first;
    logic             done;
    logic             last;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIVIDE,
    ST_EMIT
  } back_state_t;

endpackage

@@ rtl/bdlq_ram.sv @@
// ----------------------------------------------------------------------------
// bdlq_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module bdlq_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bdlq_queue.sv @@
// ----------------------------------------------------------------------------
// bdlq_queue
// short register queue between the front and back parts
// ----------------------------------------------------------------------------
module bdlq_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bdlq_pkg::entry_t push_data,
  input  logic            pop,
  output bdlq_pkg::entry_t head,
  output logic            empty,
  output logic            full
);
  import bdlq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t         slots [DEPTH];
  logic [AW-1:0]  wptr;
  logic [AW-1:0]  rptr;
  logic [AW:0]    count;

  assign empty = (count == '0);
  assign full  = (count == (AW+1)'(DEPTH));
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

@@ rtl/bdlq_front.sv @@
// ----------------------------------------------------------------------------
// bdlq_front
// raster position tracking and block classification of incoming pixels
// ----------------------------------------------------------------------------
module bdlq_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_FACTOR = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [bdlq_pkg::CFG_W-1:0]         frame_width,
  input  logic [bdlq_pkg::CFG_W-1:0]         frame_height,
  input  logic [bdlq_pkg::FACTOR_W-1:0]      block_factor,
  input  logic                               accept,
  input  bdlq_pkg::pixel_t                   pixel,
  output logic                               push,
  output bdlq_pkg::entry_t                   push_data,
  output logic [$clog2(MAX_FACTOR+1)-1:0]    factor
);
  import bdlq_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(HEIGHT_MAX);
  localparam int HW    = $clog2(HEIGHT_MAX + 1);
  localparam int FW    = $clog2(MAX_FACTOR + 1);
  localparam int SUB_W = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int PW    = POS_W + 1 + FW;
  localparam int CW    = (PW > CFG_W) ? PW + 1 : CFG_W + 1;

  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic [SUB_W-1:0] sub_col;
  logic [SUB_W-1:0] sub_row;
  logic [POS_W-1:0] blk_col;
  logic [POS_W-1:0] blk_row;

  logic [COL_W-1:0] c_in_col;
  logic [ROW_W-1:0] c_in_row;
  logic [SUB_W-1:0] c_sub_col;
  logic [SUB_W-1:0] c_sub_row;
  logic [POS_W-1:0] c_blk_col;
  logic [POS_W-1:0] c_blk_row;

  logic [WW-1:0]    w;
  logic [HW-1:0]    h;
  logic [PW-1:0]    col_end;
  logic [PW-1:0]    row_end;
  logic             col_ok;
  logic             row_ok;
  logic             col_last;
  logic             row_last;
  logic             sub_col_end;
  logic             sub_row_end;

  always_comb begin
    if (frame_width == '0) begin
      w = WW'(1);
    end else if ({1'b0, frame_width} > (CFG_W+1)'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h = HW'(1);
    end else if ({1'b0, frame_height} > (CFG_W+1)'(HEIGHT_MAX)) begin
      h = HW'(HEIGHT_MAX);
    end else begin
      h = HW'(frame_height);
    end
    if (block_factor == '0) begin
      factor = FW'(1);
    end else if ({1'b0, block_factor} > (FACTOR_W+1)'(MAX_FACTOR)) begin
      factor = FW'(MAX_FACTOR);
    end else begin
      factor = FW'(block_factor);
    end
  end

  always_comb begin
    if (pixel.frame_start) begin
      c_in_col  = '0;
      c_in_row  = '0;
      c_sub_col = '0;
      c_sub_row = '0;
      c_blk_col = '0;
      c_blk_row = '0;
    end else begin
      c_in_col  = in_col;
      c_in_row  = in_row;
      c_sub_col = sub_col;
      c_sub_row = sub_row;
      c_blk_col = blk_col;
      c_blk_row = blk_row;
    end
  end

  // block end positions, (count + 1) * f
  assign col_end = PW'({1'b0, c_blk_col} + 1'b1) * PW'(factor);
  assign row_end = PW'({1'b0, c_blk_row} + 1'b1) * PW'(factor);
  assign col_ok   = CW'(col_end) <= CW'(w);
  assign row_ok   = CW'(row_end) <= CW'(h);
  assign col_last = (CW'(col_end) + CW'(factor)) > CW'(w);
  assign row_last = (CW'(row_end) + CW'(factor)) > CW'(h);
  assign sub_col_end = (FW+1)'(c_sub_col) == (FW+1)'(factor) - 1'b1;
  assign sub_row_end = (FW+1)'(c_sub_row) == (FW+1)'(factor) - 1'b1;

  assign push = accept && col_ok && row_ok;

  always_comb begin
    push_data.first = (c_sub_col == '0) && (c_sub_row == '0);
    push_data.done  = sub_col_end && sub_row_end;
    push_data.last  = col_last && row_last;
    push_data.col   = c_blk_col;
    push_data.row   = c_blk_row;
    push_data.red   = pixel.red;
    push_data.green = pixel.green;
    push_data.blue  = pixel.blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      sub_col <= '0;
      sub_row <= '0;
      blk_col <= '0;
      blk_row <= '0;
    end else if (accept) begin
      if ((WW+1)'(c_in_col) + 1'b1 >= (WW+1)'(w)) begin
        in_col  <= '0;
        sub_col <= '0;
        blk_col <= '0;
        if ((HW+1)'(c_in_row) + 1'b1 >= (HW+1)'(h)) begin
          in_row  <= '0;
          sub_row <= '0;
          blk_row <= '0;
        end else begin
          in_row <= c_in_row + 1'b1;
          if ((FW+1)'(c_sub_row) + 1'b1 >= (FW+1)'(factor)) begin
            sub_row <= '0;
            blk_row <= c_blk_row + 1'b1;
          end else begin
            sub_row <= c_sub_row + 1'b1;
            blk_row <= c_blk_row;
          end
        end
      end else begin
        in_col  <= c_in_col + 1'b1;
        in_row  <= c_in_row;
        sub_row <= c_sub_row;
        blk_row <= c_blk_row;
        if ((FW+1)'(c_sub_col) + 1'b1 >= (FW+1)'(factor)) begin
          sub_col <= '0;
          blk_col <= c_blk_col + 1'b1;
        end else begin
          sub_col <= c_sub_col + 1'b1;
          blk_col <= c_blk_col;
        end
      end
    end
  end

endmodule

@@ rtl/bdlq_back.sv @@
// ----------------------------------------------------------------------------
// bdlq_back
// column accumulation, rounded mean division and luma quantization
// ----------------------------------------------------------------------------
module bdlq_back #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_FACTOR = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [$clog2(MAX_FACTOR+1)-1:0] factor,
  input  bdlq_pkg::entry_t                head,
  input  logic                            empty,
  output logic                            pop,
  output logic                            result_valid,
  input  logic                            result_stall,
  output bdlq_pkg::result_t               result
);
  import bdlq_pkg::*;

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int FW    = $clog2(MAX_FACTOR + 1);
  localparam int DW    = 2 * FW + 1;
  localparam int RW    = DW + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int MW    = 3 * SUM_W;

  back_state_t      state;
  back_state_t      state_next;
  entry_t           item;
  logic [CNT_W-1:0] div_cnt;
  logic [DW-1:0]    divisor;
  logic [NUM_W-1:0] quo [3];
  logic [RW-1:0]    rem [3];

  logic             ram_we;
  logic [AW-1:0]    ram_raddr;
  logic [MW-1:0]    ram_rdata;
  logic [MW-1:0]    ram_wdata;
  logic [SUM_W-1:0] new_sum [3];
  logic [7:0]       pix [3];
  logic [7:0]       mean [3];
  logic [17:0]      luma;
  logic [7:0]       gray;
  logic             load_result;
  logic [2*FW-1:0]  ff;

  assign pix[0] = item.red;
  assign pix[1] = item.green;
  assign pix[2] = item.blue;
  assign ff     = (2*FW)'(factor) * (2*FW)'(factor);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (item.first) begin
        new_sum[i] = SUM_W'(pix[i]);
      end else begin
        new_sum[i] = ram_rdata[(2-i)*SUM_W +: SUM_W] + SUM_W'(pix[i]);
      end
    end
    ram_wdata = {new_sum[0], new_sum[1], new_sum[2]};
  end

  assign ram_raddr = AW'(head.col);

  bdlq_ram #(
    .WIDTH(MW),
    .DEPTH(MAX_WIDTH)
  ) u_sums (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(item.col)),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mean[i] = (quo[i] > NUM_W'(255)) ? 8'd255 : quo[i][7:0];
    end
    luma = 18'(mean[0]) * 18'(COEF_RED) + 18'(mean[1]) * 18'(COEF_GREEN)
         + 18'(mean[2]) * 18'(COEF_BLUE);
    gray = luma[17:10];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!empty) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = item.done ? ST_DIVIDE : ST_IDLE;
      end
      ST_DIVIDE: begin
        if (div_cnt == CNT_W'(NUM_W - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!result_valid || !result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    ram_we      = 1'b0;
    load_result = 1'b0;
    case (state)
      ST_IDLE:   pop = !empty;
      ST_READ:   ram_we = 1'b1;
      ST_DIVIDE: ;
      ST_EMIT:   load_result = !result_valid || !result_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item <= head;
    end
    if (state == ST_READ) begin
      div_cnt <= '0;
      divisor <= {ff, 1'b0};
      for (int i = 0; i < 3; i++) begin
        quo[i] <= {new_sum[i], 1'b0} + NUM_W'(ff);
        rem[i] <= '0;
      end
    end else if (state == ST_DIVIDE) begin
      div_cnt <= div_cnt + 1'b1;
      for (int i = 0; i < 3; i++) begin
        if ({rem[i][RW-2:0], quo[i][NUM_W-1]} >= RW'(divisor)) begin
          rem[i] <= {rem[i][RW-2:0], quo[i][NUM_W-1]} - RW'(divisor);
          quo[i] <= {quo[i][NUM_W-2:0], 1'b1};
        end else begin
          rem[i] <= {rem[i][RW-2:0], quo[i][NUM_W-1]};
          quo[i] <= {quo[i][NUM_W-2:0], 1'b0};
        end
      end
    end
    if (load_result) begin
      result.gray_level  <= gray;
      result.shade_index <= 5'((9'(gray) + 9'd8) >> 4);
      result.out_column  <= item.col;
      result.out_row     <= item.row;
      result.frame_last  <= item.last;
    end
  end

endmodule

@@ rtl/box_downsample_luma_quantizer_top.sv @@
// ----------------------------------------------------------------------------
// box_downsample_luma_quantizer_top
// box filter downsampler of rgb pixels with gray level and shade output
// ----------------------------------------------------------------------------
// channel   direction  handshake                   payload
// pixel     in         pixel_valid / pixel_stall   pixel (pixel_t)
// result    out        result_valid / result_stall result (result_t)
// config    in         wr_en                       wr_index, wr_data
//
// a pixel is taken whenever the queue is not full; the back part pops each
// pixel and does the read-modify-write of the column ram in its idle and read
// states; a completing pixel adds 22 divider steps and an output state
// a 4-deep queue lets the front take pixels while the back is dividing
// reset is synchronous; the column sums are not cleared and hold garbage
// until the first pixel of each block writes them
// ----------------------------------------------------------------------------
module box_downsample_luma_quantizer_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_FACTOR = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pixel_valid,
  output logic                         pixel_stall,
  input  bdlq_pkg::pixel_t             pixel,
  output logic                         result_valid,
  input  logic                         result_stall,
  output bdlq_pkg::result_t            result,
  input  logic                         wr_en,
  input  logic [1:0]                   wr_index,
  input  logic [bdlq_pkg::CFG_W-1:0]   wr_data
);
  import bdlq_pkg::*;

  localparam int FW = $clog2(MAX_FACTOR + 1);

  logic [CFG_W-1:0]    frame_width;
  logic [CFG_W-1:0]    frame_height;
  logic [FACTOR_W-1:0] block_factor;
  logic [FW-1:0]       factor;
  logic                accept;
  logic                push;
  entry_t              push_data;
  logic                pop;
  entry_t              head;
  logic                empty;
  logic                full;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(640);
      frame_height <= CFG_W'(480);
      block_factor <= FACTOR_W'(1);
    end else if (wr_en) begin
      case (wr_index)
        REG_FRAME_WIDTH:  frame_width  <= wr_data;
        REG_FRAME_HEIGHT: frame_height <= wr_data;
        REG_BLOCK_FACTOR: block_factor <= wr_data[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign pixel_stall = full;
  assign accept      = pixel_valid && !full;

  bdlq_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_FACTOR(MAX_FACTOR)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .block_factor(block_factor),
    .accept      (accept),
    .pixel       (pixel),
    .push        (push),
    .push_data   (push_data),
    .factor      (factor)
  );

  bdlq_queue #(
    .DEPTH(4)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  bdlq_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_FACTOR(MAX_FACTOR)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .factor      (factor),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

@@ rtl/bdlq_checker.sv @@
// ----------------------------------------------------------------------------
// bdlq_checker
// port level checks of the box downsample luma quantizer
// ----------------------------------------------------------------------------
module bdlq_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input bdlq_pkg::result_t result
);
  import bdlq_pkg::*;

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_shade: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.shade_index == 5'((9'(result.gray_level) + 9'd8) >> 4))
    else $error("shade index does not match gray level");

  a_gray_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.gray_level <= 8'd254)
    else $error("gray level out of range");

endmodule

bind box_downsample_luma_quantizer_top bdlq_checker u_bdlq_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// random and directed pixel streams through the box downsampler; a scoreboard
// class predicts each reduced pixel and checks results in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bdlq_pkg::*;

  class block_scoreboard;
    int unsigned frame_w = 640;
    int unsigned frame_h = 480;
    int unsigned factor = 1;
    bit [19:0] red_acc [4096];
    bit [19:0] green_acc [4096];
    bit [19:0] blue_acc [4096];
    int unsigned col_pos, row_pos, sub_col, sub_row, blk_col, blk_row;
    result_t pending[$];
    int errors;

    function void set_reg(logic [1:0] idx, int unsigned val);
      case (idx)
        REG_FRAME_WIDTH: frame_w = val & 13'h1fff;
        REG_FRAME_HEIGHT: frame_h = val & 13'h1fff;
        REG_BLOCK_FACTOR: factor = val & 7'h7f;
        default: ;
      endcase
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function int unsigned mean(bit [19:0] sum, int unsigned f);
      int unsigned m;
      m = (2 * sum + f * f) / (2 * f * f);
      return (m > 255) ? 255 : m;
    endfunction

    function void note_pixel(pixel_t p);
      int unsigned w, h, f, bx, by, c, gray;
      result_t r;
      w = clamp(frame_w, 1, 4096);
      h = clamp(frame_h, 1, 4096);
      f = clamp(factor, 1, 64);
      bx = w / f;
      by = h / f;
      if (p.frame_start) begin
        {col_pos, row_pos, sub_col, sub_row, blk_col, blk_row} = '0;
      end
      if (blk_col < bx && blk_row < by) begin
        c = blk_col;
        if (sub_col == 0 && sub_row == 0) begin
          red_acc[c] = p.red;
          green_acc[c] = p.green;
          blue_acc[c] = p.blue;
        end else begin
          red_acc[c] += p.red;
          green_acc[c] += p.green;
          blue_acc[c] += p.blue;
        end
        if (sub_col == f - 1 && sub_row == f - 1) begin
          gray = (306 * mean(red_acc[c], f) + 601 * mean(green_acc[c], f)
                  + 116 * mean(blue_acc[c], f)) >> 10;
          r.gray_level = gray[7:0];
          r.shade_index = 5'((gray + 8) >> 4);
          r.out_column = c[11:0];
          r.out_row = blk_row[11:0];
          r.frame_last = (c == bx - 1 && blk_row == by - 1);
          pending.push_back(r);
        end
      end
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        sub_col = 0;
        blk_col = 0;
        if (row_pos + 1 >= h) begin
          row_pos = 0;
          sub_row = 0;
          blk_row = 0;
        end else begin
          row_pos++;
          if (sub_row + 1 >= f) begin
            sub_row = 0;
            blk_row = (blk_row + 1) & 12'hfff;
          end else begin
            sub_row++;
          end
        end
      end else begin
        col_pos++;
        if (sub_col + 1 >= f) begin
          sub_col = 0;
          blk_col = (blk_col + 1) & 12'hfff;
        end else begin
          sub_col++;
        end
      end
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report("unexpected transaction, column", got.out_column, 0);
        return;
      end
      want = pending.pop_front();
      if (got.gray_level !== want.gray_level) report("gray_level", got.gray_level, want.gray_level);
      if (got.shade_index !== want.shade_index)
        report("shade_index", got.shade_index, want.shade_index);
      if (got.out_column !== want.out_column) report("out_column", got.out_column, want.out_column);
      if (got.out_row !== want.out_row) report("out_row", got.out_row, want.out_row);
      if (got.frame_last !== want.frame_last) report("frame_last", got.frame_last, want.frame_last);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic pixel_valid = 0;
  logic pixel_stall;
  pixel_t pixel = '0;
  logic result_valid;
  logic result_stall = 0;
  result_t result;
  logic wr_en = 0;
  logic [1:0] wr_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] wr_data = '0;

  block_scoreboard sb = new();
  int sent;
  bit hold_request;

  box_downsample_luma_quantizer_top dut (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int stall_run, free_run;
    stall_run = 0;
    free_run = 50;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        stall_run = 600;
        free_run = 0;
      end
      if (stall_run > 0) begin
        stall_run--;
        result_stall <= 1;
      end else if (free_run > 0) begin
        free_run--;
        result_stall <= 0;
      end else begin
        result_stall <= 0;
        if ($urandom_range(0, 9) < 3) free_run = $urandom_range(20, 80);
        else if ($urandom_range(0, 9) == 0) stall_run = $urandom_range(20, 60);
        else stall_run = $urandom_range(1, 3);
      end
    end
  end

  task send_pixel(logic start, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap, sel;
    sel = $urandom_range(0, 99);
    gap = (sel < 60) ? 0 : ((sel < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40));
    @(negedge clk);
    if (gap > 0) begin
      pixel_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    pixel_valid <= 1;
    pixel <= '{frame_start: start, red: r, green: g, blue: b};
    do @(posedge clk); while (pixel_stall);
    sb.note_pixel('{frame_start: start, red: r, green: g, blue: b});
    sent++;
  endtask

  task write_reg(logic [1:0] idx, int unsigned val);
    @(negedge clk);
    pixel_valid <= 0;
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= val[CFG_W-1:0];
    sb.set_reg(idx, val);
    @(negedge clk);
    wr_en <= 0;
  endtask

  task drain;
    @(negedge clk);
    pixel_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task configure(int unsigned w, int unsigned h, int unsigned f);
    drain();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_BLOCK_FACTOR, f);
  endtask

  // n random pixels; frame_start on the first, mostly at frame boundaries, rarely as noise
  task random_frames(int unsigned n, int unsigned frame_len);
    logic start;
    for (int unsigned k = 0; k < n; k++) begin
      if (k == 0) start = 1;
      else if (k % frame_len == 0) start = ($urandom_range(0, 4) != 0);
      else start = ($urandom_range(0, 99) == 0);
      send_pixel(start, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int unsigned w, h, f, phase;
    repeat (5) @(posedge clk);
    rst <= 0;

    // reset defaults: every pixel is a whole block
    send_pixel(1, 8'd0, 8'd0, 8'd0);
    send_pixel(0, 8'd255, 8'd255, 8'd255);
    send_pixel(0, 8'd255, 8'd0, 8'd0);
    send_pixel(0, 8'd0, 8'd255, 8'd0);
    send_pixel(0, 8'd0, 8'd0, 8'd255);
    // full white 2x2 block, top gray
    configure(2, 2, 2);
    repeat (4) send_pixel(sb.col_pos == 0 && sb.row_pos == 0, 8'd255, 8'd255, 8'd255);
    // factor larger than frame
    configure(3, 3, 4);
    random_frames(9, 9);
    // zero registers clamp to 1x1, factor 1
    configure(0, 0, 0);
    random_frames(3, 1);
    // oversized registers clamp, no whole block
    configure(8191, 1, 127);
    random_frames(4, 4096);
    // leftover columns and rows, then row wrap without frame_start
    configure(5, 3, 2);
    send_pixel(1, 8'd255, 8'd0, 8'd128);
    repeat (29) send_pixel(0, 8'($urandom), 8'($urandom), 8'($urandom));

    phase = 0;
    while (sent < 1400) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      f = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      configure(w, h, f);
      if (phase == 3) hold_request = 1;
      random_frames($urandom_range(30, 120), w * h);
      phase++;
    end

    drain();
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
